[rtl/sidp_pkg.sv]
// Package for the INQUIRY descriptor parser: field widths, offsets and
// the result record passed from the state module to the top level.
// No dependencies.
`default_nettype none
package sidp_pkg;

    localparam int unsigned POS_W      = 7;
    localparam int unsigned END_W      = 9;
    localparam int unsigned CODE_W     = 16;
    localparam int unsigned CNT_W      = 4;
    localparam int unsigned SLOTS      = 8;
    localparam int unsigned SLOT_IDX_W = 3;
    localparam int unsigned OUT_W      = 144;

    localparam logic [POS_W-1:0] VERSION_AT = 7'd2;
    localparam logic [POS_W-1:0] ADDLEN_AT  = 7'd4;
    localparam logic [POS_W-1:0] HDR_LAST   = 7'd4;
    localparam logic [POS_W-1:0] VD_FIRST   = 7'd58;
    localparam logic [POS_W-1:0] VD_END     = 7'd74;
    localparam logic [POS_W-1:0] POS_MAX    = 7'd127;
    localparam logic [END_W-1:0] HDR_LEN    = 9'd5;
    localparam logic [CNT_W-1:0] SLOTS_CNT  = 4'd8;

    typedef struct packed {
        logic                          parse_ok;
        logic [7:0]                    rev_byte;
        logic [CNT_W-1:0]              code_total;
        logic [SLOTS-1:0][CODE_W-1:0]  descriptor;
    } t_result;

endpackage
`default_nettype wire

[rtl/sidp_state.sv]
// Per-reply parse state: position counter, header fields and the
// compacted descriptor slots. Builds the result record on the last beat.
// Depends on sidp_pkg.
`default_nettype none
module sidp_state (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_beat,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_last,
    output sidp_pkg::t_result    o_result
);

    logic [sidp_pkg::POS_W-1:0]                          r_pos, n_pos;
    logic [sidp_pkg::END_W-1:0]                          r_end, n_end;
    logic [7:0]                                          r_version, n_version;
    logic [7:0]                                          r_high, n_high;
    logic [sidp_pkg::SLOTS-1:0][sidp_pkg::CODE_W-1:0]    r_store, n_store;
    logic [sidp_pkg::CNT_W-1:0]                          r_count, n_count;
    logic [sidp_pkg::CODE_W-1:0]                         code;
    logic [sidp_pkg::END_W-1:0]                          pos_next_wide;
    logic                                                in_vd;
    logic                                                ok;

    always_comb begin
        n_pos         = r_pos;
        n_end         = r_end;
        n_version     = r_version;
        n_high        = r_high;
        n_store       = r_store;
        n_count       = r_count;
        code          = {r_high, i_byte};
        pos_next_wide = {2'b00, r_pos} + 9'd1;
        in_vd         = (r_pos >= sidp_pkg::VD_FIRST) && (r_pos < sidp_pkg::VD_END);
        if (r_pos == sidp_pkg::VERSION_AT) begin
            n_version = i_byte;
        end
        if (r_pos == sidp_pkg::ADDLEN_AT) begin
            n_end = sidp_pkg::HDR_LEN + {1'b0, i_byte};
        end
        if (in_vd) begin
            if (!r_pos[0]) begin
                n_high = i_byte;
            end else if (pos_next_wide <= r_end) begin
                if ((code != '0) && (r_count < sidp_pkg::SLOTS_CNT)) begin
                    n_store[r_count[sidp_pkg::SLOT_IDX_W-1:0]] = code;
                    n_count = r_count + 4'd1;
                end
            end
        end
        if (r_pos < sidp_pkg::POS_MAX) begin
            n_pos = r_pos + 7'd1;
        end
    end

    always_comb begin
        ok       = (r_pos >= sidp_pkg::HDR_LAST);
        o_result = '0;
        if (ok) begin
            o_result.parse_ok   = 1'b1;
            o_result.rev_byte   = n_version;
            o_result.code_total = n_count;
            o_result.descriptor = n_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_end     <= '0;
            r_version <= '0;
            r_high    <= '0;
            r_store   <= '0;
            r_count   <= '0;
        end else if (i_beat) begin
            if (i_last) begin
                r_pos     <= '0;
                r_end     <= '0;
                r_version <= '0;
                r_high    <= '0;
                r_store   <= '0;
                r_count   <= '0;
            end else begin
                r_pos     <= n_pos;
                r_end     <= n_end;
                r_version <= n_version;
                r_high    <= n_high;
                r_store   <= n_store;
                r_count   <= n_count;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sidp_pkg::SLOTS_CNT)
        else $error("descriptor count beyond slot total");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_beat && i_last) |=> (r_pos == '0) && (r_count == '0))
        else $error("state not cleared after last beat");

    a_count_needs_vd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos <= sidp_pkg::VD_FIRST) |-> (r_count == '0))
        else $error("descriptor counted before descriptor area");

endmodule
`default_nettype wire

[rtl/scsi_inquiry_descriptor_parse.sv]
// Top level of the INQUIRY descriptor parser: byte stream in, one packed
// result beat out per reply. Depends on sidp_pkg and sidp_state.
//
//   channel   dir  beat holds
//   s_axis    in   tdata = reply byte, tlast = final byte of the reply
//   m_axis    out  tdata = parse result, one beat per reply
//
// One byte is taken every cycle while s_axis_tready is high; a reply's result
// is registered and appears in the cycle after its last byte is accepted.
// The output register holds a result until taken; input stalls only while a
// result is held and m_axis_tready is low.
// Synchronous active-low reset clears all parse state and the output valid.
`default_nettype none
module scsi_inquiry_descriptor_parse (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output      logic                          s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,  // byte_value
    input  wire logic                          s_axis_tlast,  // last_byte
    output      logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // parse_ok, rev_byte, code_total, descriptor_0 .. descriptor_7, zero pad
    output      logic [sidp_pkg::OUT_W-1:0]    m_axis_tdata
);

    localparam int unsigned RES_W = $bits(sidp_pkg::t_result);

    logic               beat;
    sidp_pkg::t_result  result;
    sidp_pkg::t_result  packed_res;
    logic               r_valid;
    logic [RES_W-1:0]   r_data;
    logic [RES_W-1:0]   flat;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign beat          = s_axis_tvalid && s_axis_tready;

    sidp_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (beat),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_result (result)
    );

    // reorder into lowest-field-first wire layout
    always_comb begin
        packed_res = result;
        flat = '0;
        flat[0]    = packed_res.parse_ok;
        flat[8:1]  = packed_res.rev_byte;
        flat[12:9] = packed_res.code_total;
        for (int k = 0; k < sidp_pkg::SLOTS; k++) begin
            flat[13 + k*sidp_pkg::CODE_W +: sidp_pkg::CODE_W] = packed_res.descriptor[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (beat && s_axis_tlast) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
        if (beat && s_axis_tlast) begin
            r_data <= flat;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {{(sidp_pkg::OUT_W - RES_W){1'b0}}, r_data};

    a_rise_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> $past(beat && s_axis_tlast))
        else $error("result raised without a last beat");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !m_axis_tready) |-> !beat)
        else $error("input taken while result stalled");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !m_axis_tready) |=> (r_valid && $stable(r_data)))
        else $error("stalled result changed");

endmodule
`default_nettype wire
